>>> sv/bbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbf_pkg: shared types and constants of the 3x3 box filter
// beat types for both channels, defaults for the top-level parameters
// ----------------------------------------------------------------------------
package bbf_pkg;

   localparam int MAX_SIDE_DEF     = 1024;
   localparam int CHANNEL_BITS_DEF = 16;
   localparam int SIDE_REG_W       = 11;
   localparam int OUT_W            = 16;
   localparam int RSP_DEPTH        = 16;

   localparam logic [SIDE_REG_W-1:0] SIDE_RESET = SIDE_REG_W'(32);

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [OUT_W-1:0]  in_red;
      logic [OUT_W-1:0]  in_green;
      logic [OUT_W-1:0]  in_blue;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0]  out_red;
      logic [OUT_W-1:0]  out_green;
      logic [OUT_W-1:0]  out_blue;
      logic              frame_end;
      logic              run_last;
   } rsp_type;

   typedef struct packed {
      logic push_first;
      logic push_second;
   } push_type;

endpackage

>>> sv/bbf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbf_ram: generic synchronous ram
// one write port, two read ports, read data registered, old data on collision
// ----------------------------------------------------------------------------
module bbf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule

>>> sv/bbf_rsp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbf_rsp_fifo: result queue
// takes up to two beats a cycle, hands out one; depth a power of two
// ----------------------------------------------------------------------------
module bbf_rsp_fifo
   import bbf_pkg::*;
#(
   parameter int DEPTH = RSP_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  push_type                   push,
   input  rsp_type                    wr_first,
   input  rsp_type                    wr_second,
   output logic [$clog2(DEPTH+1)-1:0] count,
   output logic                       rd_valid,
   input  logic                       rd_ready,
   output rsp_type                    rd_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   wr_ptr_nx;
   logic [CNT_W-1:0]   n_push;
   logic               pop;

   assign pop       = (count_ff != '0) && rd_ready;
   assign n_push    = CNT_W'(push.push_first) + CNT_W'(push.push_second);
   assign wr_ptr_nx = wr_ptr_ff + 1'b1;
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(n_push);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + n_push - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push_first) begin
         mem_ff[wr_ptr_ff] <= wr_first;
      end
      if (push.push_second) begin
         mem_ff[wr_ptr_nx] <= wr_second;
      end
   end

   assign count    = count_ff;
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];

endmodule

>>> sv/box_filter_3x3_edge_aware.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_3x3_edge_aware: streaming 3x3 edge-aware box blur, square rgb
// two line rams, column-sum window, reciprocal multiply, result queue
// ----------------------------------------------------------------------------
// a result beat passes stages 1 to 4 and the result queue on its way to the output
// throughput: one beat per cycle while req_ready is high; the line rams are read in the accept
//   cycle and written back in the next, one access per port per cycle
// req_ready drops only when the result queue plus the four pipe stages could overfill
// reset: synchronous, clears counters, pipe valids and queue; side returns to 32
// the line rams are not cleared: a new frame overwrites a row before it is read

module box_filter_3x3_edge_aware
   import bbf_pkg::*;
#(
   parameter int MAX_SIDE     = MAX_SIDE_DEF,
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [SIDE_REG_W-1:0] csr_wdata
);

   // widths
   localparam int ADDR_W = $clog2(MAX_SIDE);
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int CMP_W  = (SIDE_W > SIDE_REG_W) ? SIDE_W : SIDE_REG_W;
   localparam int CB     = CHANNEL_BITS;
   localparam int PIX_W  = 3 * CB;
   localparam int COL_W  = CB + 2;           // three rows of one column
   localparam int SUM_W  = CB + 4;           // up to nine pixels
   localparam int K      = SUM_W + 4;        // reciprocal scale, exact for divisors to 16
   localparam int MW     = K + 1;
   localparam int PW     = SUM_W + MW;
   localparam int CNT_W  = $clog2(RSP_DEPTH + 1);

   // rounded-up reciprocals ceil(2^K / n) for every neighbourhood size
   localparam longint ONE_K = longint'(1) << K;
   localparam logic [MW-1:0] RECIP_1 = MW'(ONE_K);
   localparam logic [MW-1:0] RECIP_2 = MW'((ONE_K + 1) / 2);
   localparam logic [MW-1:0] RECIP_3 = MW'((ONE_K + 2) / 3);
   localparam logic [MW-1:0] RECIP_4 = MW'((ONE_K + 3) / 4);
   localparam logic [MW-1:0] RECIP_6 = MW'((ONE_K + 5) / 6);
   localparam logic [MW-1:0] RECIP_9 = MW'((ONE_K + 8) / 9);

   // ---------------------------------------------------------------- config
   logic [SIDE_REG_W-1:0] side_ff;
   logic [CMP_W-1:0]      side_ext;
   logic [SIDE_W-1:0]     side;
   logic [SIDE_W-1:0]     side_m1;
   logic                  side_ge2;

   assign side_ext = CMP_W'(side_ff);

   // effective side clamped to 1..MAX_SIDE
   always_comb begin
      if (side_ext == '0) begin
         side = SIDE_W'(1);
      end else if (side_ext > CMP_W'(MAX_SIDE)) begin
         side = SIDE_W'(MAX_SIDE);
      end else begin
         side = side_ext[SIDE_W-1:0];
      end
   end

   assign side_m1  = side - 1'b1;
   assign side_ge2 = (side > SIDE_W'(1));

   // ---------------------------------------------------------------- stage 0
   // raster counters live here and move at accept time
   logic [ADDR_W-1:0] col_ff, col_in;
   logic [SIDE_W-1:0] row_ff, row_in;
   logic [SIDE_W-1:0] drain_ff, drain_in;

   logic              req_fire;
   logic              is_pix;
   logic              frame_done;
   logic              flush_eff;
   logic [SIDE_W-1:0] cur_r;
   logic [ADDR_W-1:0] cur_c;
   logic [SIDE_W-1:0] cur_c_w;
   logic [SIDE_W-1:0] col_next;
   logic [ADDR_W-1:0] d_addr;
   logic [ADDR_W-1:0] ra_a, ra_b;

   assign req_fire   = req_valid && req_ready;
   assign is_pix     = (req_data.op == OP_PIXEL);
   assign frame_done = (row_ff >= side);
   assign flush_eff  = frame_done && (drain_ff < side);
   // a pixel after a finished frame starts the next one
   assign cur_r      = frame_done ? '0 : row_ff;
   assign cur_c      = frame_done ? '0 : col_ff;
   assign cur_c_w    = SIDE_W'(cur_c);
   assign col_next   = cur_c_w + 1'b1;
   assign d_addr     = drain_ff[ADDR_W-1:0];
   assign ra_a       = is_pix ? cur_c : d_addr;
   assign ra_b       = d_addr + 1'b1;

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      drain_in = drain_ff;
      if (csr_we) begin
         col_in   = '0;
         row_in   = '0;
         drain_in = '0;
      end else if (req_fire && is_pix) begin
         if (frame_done) begin
            drain_in = '0;
         end
         if (col_next >= side) begin
            col_in = '0;
            row_in = cur_r + 1'b1;
         end else begin
            col_in = col_next[ADDR_W-1:0];
            row_in = cur_r;
         end
      end else if (req_fire && flush_eff) begin
         drain_in = drain_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff  <= SIDE_RESET;
         col_ff   <= '0;
         row_ff   <= '0;
         drain_ff <= '0;
      end else begin
         if (csr_we) begin
            side_ff <= csr_wdata;
         end
         col_ff   <= col_in;
         row_ff   <= row_in;
         drain_ff <= drain_in;
      end
   end

   // per-beat control worked out at accept time
   logic       r_ge1, r_ge2, c_ge1, c_ge2, c_last, d_ge1, d_last;
   logic       res_a_in, res_b_in, use_up_in, a0_in, a2_in, fe_in;
   logic [1:0] rows_in, cols_a_in, cols_b_in;
   logic [3:0] cnt_a_in, cnt_b_in;

   assign r_ge1  = (cur_r != '0);
   assign r_ge2  = (cur_r > SIDE_W'(1));
   assign c_ge1  = (cur_c != '0);
   assign c_ge2  = (cur_c_w > SIDE_W'(1));
   assign c_last = (cur_c_w == side_m1);
   assign d_ge1  = (drain_ff != '0);
   assign d_last = (drain_ff == side_m1);

   always_comb begin
      if (is_pix) begin
         res_a_in  = r_ge1 && c_ge1;
         res_b_in  = r_ge1 && c_last;
         use_up_in = r_ge2;
         a0_in     = c_ge2;
         a2_in     = 1'b1;
         fe_in     = 1'b0;
         rows_in   = r_ge2 ? 2'd3 : 2'd2;
      end else begin
         res_a_in  = flush_eff;
         res_b_in  = 1'b0;
         use_up_in = side_ge2;
         a0_in     = d_ge1;
         a2_in     = !d_last;
         fe_in     = d_last;
         rows_in   = side_ge2 ? 2'd2 : 2'd1;
      end
   end

   assign cols_a_in = 2'd1 + 2'(a0_in) + 2'(a2_in);
   assign cols_b_in = 2'd1 + 2'(side_ge2);
   assign cnt_a_in  = 4'(rows_in) * 4'(cols_a_in);
   assign cnt_b_in  = 4'(rows_in) * 4'(cols_b_in);

   // ---------------------------------------------------------------- stage 1
   logic              v1_ff;
   logic              pix1_ff;
   logic [ADDR_W-1:0] c1_ff;
   logic [PIX_W-1:0]  px1_ff;
   logic              res_a1_ff, res_b1_ff, use_up1_ff, a0_1_ff, a2_1_ff, b1_1_ff, fe1_ff;
   logic [3:0]        cnt_a1_ff, cnt_b1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= req_fire && (is_pix || flush_eff);
      end
   end

   always_ff @(posedge clock) begin
      pix1_ff    <= is_pix;
      c1_ff      <= cur_c;
      px1_ff     <= {req_data.in_blue[CB-1:0], req_data.in_green[CB-1:0],
                     req_data.in_red[CB-1:0]};
      res_a1_ff  <= res_a_in;
      res_b1_ff  <= res_b_in;
      use_up1_ff <= use_up_in;
      a0_1_ff    <= a0_in;
      a2_1_ff    <= a2_in;
      b1_1_ff    <= side_ge2;
      fe1_ff     <= fe_in;
      cnt_a1_ff  <= cnt_a_in;
      cnt_b1_ff  <= cnt_b_in;
   end

   // line rams: upper holds row r-2, middle row r-1
   logic              ram_we;
   logic [PIX_W-1:0]  up_rd_a, up_rd_b, mid_rd_a, mid_rd_b;
   logic [PIX_W-1:0]  up_a, up_b, mid_a, mid_b;

   // forwarding of the previous beat's write-back to the current read (side of one or two)
   logic              fwd_a_ff, fwd_b_ff;
   logic [PIX_W-1:0]  fwd_up_ff, fwd_mid_ff;

   assign ram_we = v1_ff && pix1_ff;

   always_ff @(posedge clock) begin
      fwd_a_ff   <= ram_we && (c1_ff == ra_a);
      fwd_b_ff   <= ram_we && (c1_ff == ra_b);
      fwd_up_ff  <= mid_a;
      fwd_mid_ff <= px1_ff;
   end

   assign up_a  = fwd_a_ff ? fwd_up_ff  : up_rd_a;
   assign mid_a = fwd_a_ff ? fwd_mid_ff : mid_rd_a;
   assign up_b  = fwd_b_ff ? fwd_up_ff  : up_rd_b;
   assign mid_b = fwd_b_ff ? fwd_mid_ff : mid_rd_b;

   bbf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_SIDE)
   ) u_upper (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (c1_ff),
      .wdata   (mid_a),
      .raddr_a (ra_a),
      .raddr_b (ra_b),
      .rdata_a (up_rd_a),
      .rdata_b (up_rd_b)
   );

   bbf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_SIDE)
   ) u_middle (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (c1_ff),
      .wdata   (px1_ff),
      .raddr_a (ra_a),
      .raddr_b (ra_b),
      .rdata_a (mid_rd_a),
      .rdata_b (mid_rd_b)
   );

   // sliding window kept as per-column sums; p2 is the newest column
   logic [2:0][COL_W-1:0] p1_ff, p2_ff;
   logic [2:0][COL_W-1:0] new_col, col_b;
   logic [2:0][COL_W-1:0] x0_in, x1_in, x2_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         new_col[k] = (use_up1_ff ? COL_W'(up_a[k*CB +: CB]) : '0)
                    + COL_W'(mid_a[k*CB +: CB])
                    + (pix1_ff ? COL_W'(px1_ff[k*CB +: CB]) : '0);
         col_b[k]   = (b1_1_ff ? COL_W'(up_b[k*CB +: CB]) : '0)
                    + COL_W'(mid_b[k*CB +: CB]);
      end
      if (pix1_ff) begin
         x0_in = p1_ff;
         x1_in = p2_ff;
         x2_in = new_col;
      end else begin
         // drain: left column is the previous drain's centre
         x0_in = p2_ff;
         x1_in = new_col;
         x2_in = col_b;
      end
   end

   always_ff @(posedge clock) begin
      if (v1_ff) begin
         if (pix1_ff) begin
            p1_ff <= p2_ff;
         end
         p2_ff <= new_col;
      end
   end

   // ---------------------------------------------------------------- stage 2
   logic                  v2_ff;
   logic [2:0][COL_W-1:0] x0_ff, x1_ff, x2_ff;
   logic                  res_a2_ff, res_b2_ff, a0_2_ff, a2_2_ff, b1_2_ff, fe2_ff;
   logic [3:0]            cnt_a2_ff, cnt_b2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff     <= x0_in;
      x1_ff     <= x1_in;
      x2_ff     <= x2_in;
      res_a2_ff <= res_a1_ff;
      res_b2_ff <= res_b1_ff;
      a0_2_ff   <= a0_1_ff;
      a2_2_ff   <= a2_1_ff;
      b1_2_ff   <= b1_1_ff;
      fe2_ff    <= fe1_ff;
      cnt_a2_ff <= cnt_a1_ff;
      cnt_b2_ff <= cnt_b1_ff;
   end

   logic [2:0][SUM_W-1:0] sum_a_in, sum_b_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sum_a_in[k] = (a0_2_ff ? SUM_W'(x0_ff[k]) : '0) + SUM_W'(x1_ff[k])
                     + (a2_2_ff ? SUM_W'(x2_ff[k]) : '0);
         sum_b_in[k] = (b1_2_ff ? SUM_W'(x1_ff[k]) : '0) + SUM_W'(x2_ff[k]);
      end
   end

   // ---------------------------------------------------------------- stage 3
   logic                  v3_ff;
   logic [2:0][SUM_W-1:0] sum_a_ff, sum_b_ff;
   logic                  res_a3_ff, res_b3_ff, fe3_ff;
   logic [3:0]            cnt_a3_ff, cnt_b3_ff;
   logic [MW-1:0]         recip_a, recip_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      sum_a_ff  <= sum_a_in;
      sum_b_ff  <= sum_b_in;
      res_a3_ff <= res_a2_ff;
      res_b3_ff <= res_b2_ff;
      fe3_ff    <= fe2_ff;
      cnt_a3_ff <= cnt_a2_ff;
      cnt_b3_ff <= cnt_b2_ff;
   end

   always_comb begin
      case (cnt_a3_ff)
         4'd2:    recip_a = RECIP_2;
         4'd3:    recip_a = RECIP_3;
         4'd4:    recip_a = RECIP_4;
         4'd6:    recip_a = RECIP_6;
         4'd9:    recip_a = RECIP_9;
         default: recip_a = RECIP_1;
      endcase
      case (cnt_b3_ff)
         4'd2:    recip_b = RECIP_2;
         4'd3:    recip_b = RECIP_3;
         4'd4:    recip_b = RECIP_4;
         4'd6:    recip_b = RECIP_6;
         4'd9:    recip_b = RECIP_9;
         default: recip_b = RECIP_1;
      endcase
   end

   // ---------------------------------------------------------------- stage 4
   logic               v4_ff;
   logic [2:0][PW-1:0] prod_a_ff, prod_b_ff;
   logic               res_a4_ff, res_b4_ff, fe4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         prod_a_ff[k] <= PW'(sum_a_ff[k]) * PW'(recip_a);
         prod_b_ff[k] <= PW'(sum_b_ff[k]) * PW'(recip_b);
      end
      res_a4_ff <= res_a3_ff;
      res_b4_ff <= res_b3_ff;
      fe4_ff    <= fe3_ff;
   end

   // quotients and queue write
   rsp_type  beat_a, beat_b, wr_first, wr_second;
   push_type push;

   always_comb begin
      beat_a.out_red   = OUT_W'(prod_a_ff[0][K +: CB]);
      beat_a.out_green = OUT_W'(prod_a_ff[1][K +: CB]);
      beat_a.out_blue  = OUT_W'(prod_a_ff[2][K +: CB]);
      beat_a.frame_end = fe4_ff;
      beat_a.run_last  = !res_b4_ff;
      beat_b.out_red   = OUT_W'(prod_b_ff[0][K +: CB]);
      beat_b.out_green = OUT_W'(prod_b_ff[1][K +: CB]);
      beat_b.out_blue  = OUT_W'(prod_b_ff[2][K +: CB]);
      beat_b.frame_end = 1'b0;
      beat_b.run_last  = 1'b1;
      // the last-column beat moves up when it is the only one
      wr_first         = res_a4_ff ? beat_a : beat_b;
      wr_second        = beat_b;
      push.push_first  = v4_ff && (res_a4_ff || res_b4_ff);
      push.push_second = v4_ff && res_a4_ff && res_b4_ff;
   end

   logic [CNT_W-1:0] fifo_count;
   logic [7:0]       load;

   bbf_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wr_first  (wr_first),
      .wr_second (wr_second),
      .count     (fifo_count),
      .rd_valid  (rsp_valid),
      .rd_ready  (rsp_ready),
      .rd_data   (rsp_data)
   );

   // two queue slots held for every beat still in the pipe
   assign load      = 8'(fifo_count) + {6'd0, v1_ff, 1'b0} + {6'd0, v2_ff, 1'b0}
                    + {6'd0, v3_ff, 1'b0} + {6'd0, v4_ff, 1'b0};
   assign req_ready = (load <= 8'(RSP_DEPTH - 2));

endmodule

>>> sv/bbf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbf_checker: port-level checks of the 3x3 box filter
// bound to the top level
// ----------------------------------------------------------------------------
module bbf_checker
   import bbf_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed under stall");

   // queue empty after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // input open after reset
   a_req_reset: assert property (@(posedge clock)
      $past(reset) |-> req_ready)
      else $error("input not ready right after reset");

   // the bottom-right beat comes from a drain tick and closes its run
   a_frame_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |-> rsp_data.run_last)
      else $error("frame end without run last");

endmodule

bind box_filter_3x3_edge_aware bbf_checker u_bbf_checker (.*);

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 3x3 edge-aware box filter
// streams square rgb frames of many sides through the filter, predicts every
// smoothed pixel in a scoreboard and compares each result beat field by field
// ----------------------------------------------------------------------------

class blur_scoreboard;
   localparam int LINE_DEPTH = 1024;

   int unsigned   side_reg;
   int unsigned   upper_row [LINE_DEPTH][3];
   int unsigned   middle_row[LINE_DEPTH][3];
   int unsigned   win[3][3][3];            // [row][column][channel], column 2 newest
   int unsigned   col_cnt;
   int unsigned   row_cnt;
   int unsigned   drain_col;
   bbf_pkg::rsp_type expected_px[$];
   int            mismatches;

   function new();
      side_reg   = 32;
      col_cnt    = 0;
      row_cnt    = 0;
      drain_col  = 0;
      mismatches = 0;
      foreach (win[r, c, k]) win[r][c][k] = 0;
   endfunction

   function int unsigned eff_side();
      int unsigned s;
      s = side_reg;
      if (s < 1) s = 1;
      if (s > LINE_DEPTH) s = LINE_DEPTH;
      return s;
   endfunction

   function void set_side(logic [bbf_pkg::SIDE_REG_W-1:0] v);
      side_reg  = v;
      col_cnt   = 0;
      row_cnt   = 0;
      drain_col = 0;
   endfunction

   // average over window rows rlo..2 and columns clo..2
   function bbf_pkg::rsp_type win_avg(int rlo, int clo);
      int unsigned sum[3];
      int unsigned n;
      bbf_pkg::rsp_type p;
      sum = '{0, 0, 0};
      n = 0;
      for (int r = rlo; r <= 2; r++)
         for (int c = clo; c <= 2; c++) begin
            for (int k = 0; k < 3; k++) sum[k] += win[r][c][k];
            n++;
         end
      p.out_red   = 16'(sum[0] / n);
      p.out_green = 16'(sum[1] / n);
      p.out_blue  = 16'(sum[2] / n);
      p.frame_end = 1'b0;
      p.run_last  = 1'b0;
      return p;
   endfunction

   function void note_beat(bbf_pkg::req_type rq);
      int unsigned s, c, r, lo, hi, cnt;
      int unsigned sum[3];
      int unsigned px[3];
      int rlo, n;
      bbf_pkg::rsp_type p;
      s = eff_side();
      if (rq.op == bbf_pkg::OP_FLUSH) begin
         if (row_cnt < s || drain_col >= s) return;
         lo  = (drain_col >= 1) ? drain_col - 1 : 0;
         hi  = (drain_col + 1 < s) ? drain_col + 1 : s - 1;
         sum = '{0, 0, 0};
         cnt = 0;
         for (int unsigned j = lo; j <= hi; j++) begin
            for (int k = 0; k < 3; k++) begin
               sum[k] += middle_row[j][k];
               if (s >= 2) sum[k] += upper_row[j][k];
            end
            cnt += (s >= 2) ? 2 : 1;
         end
         p.out_red   = 16'(sum[0] / cnt);
         p.out_green = 16'(sum[1] / cnt);
         p.out_blue  = 16'(sum[2] / cnt);
         p.frame_end = (drain_col == s - 1);
         p.run_last  = 1'b1;
         expected_px.push_back(p);
         drain_col++;
         return;
      end
      if (row_cnt >= s) begin
         row_cnt   = 0;
         col_cnt   = 0;
         drain_col = 0;
      end
      r = row_cnt;
      c = col_cnt;
      px = '{rq.in_red, rq.in_green, rq.in_blue};
      for (int k = 0; k < 3; k++) begin
         for (int rr = 0; rr < 3; rr++) begin
            win[rr][0][k] = win[rr][1][k];
            win[rr][1][k] = win[rr][2][k];
         end
         win[0][2][k]     = upper_row[c][k];
         win[1][2][k]     = middle_row[c][k];
         win[2][2][k]     = px[k];
         upper_row[c][k]  = middle_row[c][k];
         middle_row[c][k] = px[k];
      end
      if (r >= 1) begin
         rlo = (r >= 2) ? 0 : 1;
         n   = 0;
         if (c >= 1) begin
            expected_px.push_back(win_avg(rlo, (c >= 2) ? 0 : 1));
            n++;
         end
         if (c == s - 1) begin
            expected_px.push_back(win_avg(rlo, (s >= 2) ? 1 : 2));
            n++;
         end
         if (n > 0) expected_px[$].run_last = 1'b1;
      end
      col_cnt = c + 1;
      if (col_cnt >= s) begin
         col_cnt = 0;
         row_cnt = r + 1;
      end
   endfunction

   function void check_beat(bbf_pkg::rsp_type got);
      bbf_pkg::rsp_type want;
      if (expected_px.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result beat %h", got);
         return;
      end
      want = expected_px.pop_front();
      if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
          got.out_blue !== want.out_blue || got.frame_end !== want.frame_end ||
          got.run_last !== want.run_last) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"mismatch: expected r=%h g=%h b=%h fe=%b rl=%b, ",
                      "got r=%h g=%h b=%h fe=%b rl=%b"},
                     want.out_red, want.out_green, want.out_blue, want.frame_end,
                     want.run_last, got.out_red, got.out_green, got.out_blue,
                     got.frame_end, got.run_last);
      end
   endfunction
endclass

module tb;
   import bbf_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 12;    // pipe latency plus margin

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [SIDE_REG_W-1:0] csr_wdata = '0;

   blur_scoreboard sb = new();
   int  burst_left = 0;
   int  beats_sent = 0;
   int  idle_cycles = 0;
   int  cycle_no = 0;

   box_filter_3x3_edge_aware dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // monitors: sample both channels at the edge, before any update lands
   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      if (!reset) begin
         if (req_valid && req_ready) sb.note_beat(req_data);
         if (rsp_valid && rsp_ready) sb.check_beat(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver back-pressure: the mode steps through four settings as cycle_no advances
   always @(posedge clock) begin
      case ((cycle_no >> 8) % 4)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         2: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: begin
            rsp_ready <= ((cycle_no % 40) >= 25);   // long stalls
         end
      endcase
   end

   // watchdog: too long without a beat on either channel
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [15:0] chan_val();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // drive one beat; bursts of random length separated by random gaps
   task automatic send_beat(op_type op, logic [15:0] r, logic [15:0] g, logic [15:0] b);
      int gap;
      req_type rq;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 60);
      end
      rq.op       = op;
      rq.in_red   = r;
      rq.in_green = g;
      rq.in_blue  = b;
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      beats_sent++;
   endtask

   task automatic send_pixel();
      send_beat(OP_PIXEL, chan_val(), chan_val(), chan_val());
   endtask

   task automatic send_flush();
      // flush payload is ignored, so fill it with noise
      send_beat(OP_FLUSH, 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // wait for the filter to go quiet, then write the side register
   task automatic write_side(logic [SIDE_REG_W-1:0] v);
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.expected_px.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_side(v);
   endtask

   // one frame with optional stray flushes, then a drain of n flushes
   task automatic run_frame(int side, int n_flush, bit noisy);
      for (int i = 0; i < side * side; i++) begin
         if (noisy && $urandom_range(0, 24) == 0) send_flush();
         send_pixel();
      end
      repeat (n_flush) send_flush();
   endtask

   initial begin
      int sides[12] = '{0, 1, 2, 3, 4, 5, 6, 7, 9, 13, 16, 31};
      int s, frames;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // default side after reset: flush with nothing pending, then one row and two pixels
      send_flush();
      repeat (34) send_pixel();

      // side 3 with extreme pixels, a flush mid-frame, full drain plus one spare
      write_side(11'd3);
      send_beat(OP_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_beat(OP_PIXEL, 16'h0000, 16'hFFFF, 16'h0000);
      send_flush();
      repeat (3) send_beat(OP_PIXEL, 16'hFFFF, 16'h0000, 16'hFFFF);
      repeat (4) send_beat(OP_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      repeat (4) send_flush();
      // next frame, partly drained, then a pixel that drops the rest
      run_frame(3, 1, 0);
      send_pixel();

      // tiny images: corners only and a single pixel (zero clamps to one)
      write_side(11'd2);
      run_frame(2, 3, 0);
      write_side(11'd0);
      run_frame(1, 2, 0);
      write_side(11'd1);
      run_frame(1, 1, 0);

      // the largest side: register all-ones clamps, then the exact maximum
      write_side(11'h7FF);
      repeat (1026) send_pixel();
      write_side(11'd1024);
      repeat (10) send_pixel();

      // random frames, mostly well formed, some abandoned or noisy
      while (beats_sent < 1550) begin
         s = sides[$urandom_range(0, 11)];
         write_side(11'(s));
         if (s == 0) s = 1;
         frames = $urandom_range(1, 3);
         repeat (frames) begin
            if ($urandom_range(0, 9) == 0) begin
               // frame cut short by the next register write
               repeat ($urandom_range(0, s * s)) send_pixel();
               break;
            end
            case ($urandom_range(0, 7))
               0: run_frame(s, $urandom_range(0, s), 1);
               1: run_frame(s, s + 2, 1);
               default: run_frame(s, s, $urandom_range(0, 1));
            endcase
         end
      end

      req_valid <= 1'b0;
      while (sb.expected_px.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_px.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
